>>> rtl/core/pulse_period_tachometer_assert.svh
// Assertion macros shared by the tachometer checker.
// No dependencies; take in with a plain include.
`ifndef PULSE_PERIOD_TACHOMETER_ASSERT_SVH
`define PULSE_PERIOD_TACHOMETER_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define PPT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define PPT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/ppt_pkg.sv
// Shared types, widths and constants of the pulse period tachometer.
// No dependencies; every other RTL module imports it.
`default_nettype none

package ppt_pkg;

	localparam int AVG_DEPTH = 8;

	localparam int TIME_W  = 48;
	localparam int SUM_W   = 48;
	localparam int COUNT_W = 32;
	localparam int RPM_W   = 16;
	localparam int MIN_W   = 20;
	localparam int TMO_W   = 26;
	localparam int UPD_W   = 26;
	localparam int CFG_W   = 26;
	localparam int CIDX_W  = 2;

	localparam int DIV_W   = 48;
	localparam int DSTEP_W = $clog2(DIV_W + 1);

	localparam int POS_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
	localparam int FILL_W = $clog2(AVG_DEPTH + 1);
	localparam int TOT_W  = RPM_W + $clog2(AVG_DEPTH);

	localparam int NUM_W = 26;
	localparam logic [NUM_W-1:0] RPM_NUM = 26'd60000000;

	localparam logic [MIN_W-1:0] MIN_RESET = 20'd1000;
	localparam logic [TMO_W-1:0] TMO_RESET = 26'd1000000;
	localparam logic [RPM_W-1:0] THR_RESET = 16'd500;
	localparam logic [UPD_W-1:0] UPD_RESET = 26'd500000;

	typedef enum logic [CIDX_W-1:0] {
		CFG_MIN_INTERVAL,
		CFG_TIMEOUT,
		CFG_THRESHOLD,
		CFG_UPDATE_PERIOD
	} ppt_cfg_idx_t;

	typedef enum logic {
		OP_PULSE,
		OP_TICK
	} ppt_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIFF,
		ST_PULSE,
		ST_TICK,
		ST_CHECK,
		ST_DIV_PER,
		ST_DIV_RPM,
		ST_PUSH,
		ST_AVG,
		ST_DIV_AVG,
		ST_EMIT
	} ppt_state_t;

	typedef struct packed {
		logic              op;
		logic [TIME_W-1:0] time_us;
	} ppt_in_t;

	typedef struct packed {
		logic [RPM_W-1:0] rpm_avg;
		logic             running;
		logic             updated;
		logic             rpm_changed;
	} ppt_out_t;

	typedef struct packed {
		logic [MIN_W-1:0] min_pulse_interval_us;
		logic [TMO_W-1:0] pulse_timeout_us;
		logic [RPM_W-1:0] running_threshold_rpm;
		logic [UPD_W-1:0] update_period_us;
	} ppt_cfg_t;

	typedef struct packed {
		logic               start;
		logic [DSTEP_W-1:0] steps;
		logic [DIV_W-1:0]   dividend;
		logic [DIV_W-1:0]   divisor;
	} ppt_div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quotient;
	} ppt_div_rsp_t;

	typedef struct packed {
		logic             push;
		logic [RPM_W-1:0] value;
	} ppt_hist_req_t;

	typedef struct packed {
		logic [TOT_W-1:0]  total;
		logic [FILL_W-1:0] fill;
	} ppt_hist_rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/pulse_period_tachometer.sv
// Pulse period tachometer with moving-average rpm: top level.
// Depends on ppt_pkg, ppt_divider, ppt_history and ppt_ctrl.
//
// Each input word is a pulse edge (op 0) or an update tick (op 1) stamped with a
// 48-bit microsecond time, and each one yields exactly one output word carrying
// the held average rpm, the running flag, whether this word did an update, and
// whether raw and average rpm differed on that update. Items are worked one at
// a time. An updating tick runs all three divisions when an average period is
// formed, skips the rpm division when that period is zero, and runs only the
// moving average when no rate can be formed (timeout, no pulse, no interval).
// The single radix-2 divider is shared by the three divisions (average period,
// 48 steps; rpm from 60000000, 26 steps; moving average, 16 + log2(AVG_DEPTH)
// steps). A finished word waits in the output register, so the next input word
// is taken while it is still stalled; only a stall that outlasts the next item
// adds cycles. Configuration writes go straight into the registers and are
// meant to happen only while the block is idle. Reset clears all history at
// once; no clearing pass is needed.
`default_nettype none

module pulse_period_tachometer (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire ppt_pkg::ppt_in_t               in_word,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output ppt_pkg::ppt_out_t                   out_word,
	input  wire logic                           cfg_we,
	input  wire logic [ppt_pkg::CIDX_W-1:0]     cfg_index,
	input  wire logic [ppt_pkg::CFG_W-1:0]      cfg_data
);
	import ppt_pkg::*;

	ppt_cfg_t      cfg_q;
	ppt_div_req_t  div_req;
	ppt_div_rsp_t  div_rsp;
	ppt_hist_req_t hist_req;
	ppt_hist_rsp_t hist_rsp;
	ppt_out_t      result;
	logic          emit;
	logic          slot_free;
	logic          out_valid_q;
	ppt_out_t      out_word_q;

	// Configuration registers, written by index, no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_pulse_interval_us <= MIN_RESET;
			cfg_q.pulse_timeout_us      <= TMO_RESET;
			cfg_q.running_threshold_rpm <= THR_RESET;
			cfg_q.update_period_us      <= UPD_RESET;
		end else if (cfg_we) begin
			unique case (ppt_cfg_idx_t'(cfg_index))
				CFG_MIN_INTERVAL:  cfg_q.min_pulse_interval_us <= cfg_data[MIN_W-1:0];
				CFG_TIMEOUT:       cfg_q.pulse_timeout_us      <= cfg_data[TMO_W-1:0];
				CFG_THRESHOLD:     cfg_q.running_threshold_rpm <= cfg_data[RPM_W-1:0];
				CFG_UPDATE_PERIOD: cfg_q.update_period_us      <= cfg_data[UPD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	ppt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_word  (in_word),
		.in_stall (in_stall),
		.cfg      (cfg_q),
		.slot_free(slot_free),
		.emit     (emit),
		.result   (result),
		.div_req  (div_req),
		.div_rsp  (div_rsp),
		.hist_req (hist_req),
		.hist_rsp (hist_rsp)
	);

	ppt_divider u_divider (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	ppt_history u_history (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (hist_req),
		.rsp   (hist_rsp)
	);

	// Output register: load a finished word when the slot is empty or
	// being drained this cycle; otherwise hold it until taken.
	assign slot_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && slot_free) begin
			out_word_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

`default_nettype wire

>>> rtl/core/ppt_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Depends on ppt_pkg for widths and the request/response structs.
`default_nettype none

module ppt_divider (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ppt_pkg::ppt_div_req_t req,
	output ppt_pkg::ppt_div_rsp_t      rsp
);
	import ppt_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [DSTEP_W-1:0] cnt_q;
	logic [DIV_W-1:0]   rem_q;
	logic [DIV_W-1:0]   dvd_q;
	logic [DIV_W-1:0]   dvs_q;
	logic [DIV_W-1:0]   quo_q;

	logic [DIV_W:0]   shifted;
	logic             ge;
	logic [DIV_W-1:0] rem_next;

	// shift the next dividend bit into the partial remainder and try the subtract
	assign shifted  = {rem_q, dvd_q[DIV_W-1]};
	assign ge       = shifted >= {1'b0, dvs_q};
	assign rem_next = ge ? DIV_W'(shifted - {1'b0, dvs_q}) : shifted[DIV_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DSTEP_W'(1);
				if (cnt_q == DSTEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= '0;
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[DIV_W-2:0], ge};
			dvd_q <= {dvd_q[DIV_W-2:0], 1'b0};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

`default_nettype wire

>>> rtl/core/ppt_history.sv
// Moving-average history: ring of raw rpm samples with running total and fill.
// Depends on ppt_pkg for AVG_DEPTH, widths and the push/status structs.
`default_nettype none

module ppt_history (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire ppt_pkg::ppt_hist_req_t req,
	output ppt_pkg::ppt_hist_rsp_t      rsp
);
	import ppt_pkg::*;

	logic [RPM_W-1:0]  hist_q [AVG_DEPTH];
	logic [POS_W-1:0]  pos_q;
	logic [FILL_W-1:0] fill_q;
	logic [TOT_W-1:0]  total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AVG_DEPTH; i++) begin
				hist_q[i] <= '0;
			end
			pos_q   <= '0;
			fill_q  <= '0;
			total_q <= '0;
		end else if (req.push) begin
			// drop the oldest sample from the total, add the new one
			total_q       <= total_q - TOT_W'(hist_q[pos_q]) + TOT_W'(req.value);
			hist_q[pos_q] <= req.value;
			pos_q         <= (pos_q == POS_W'(AVG_DEPTH - 1)) ? '0 : pos_q + POS_W'(1);
			if (fill_q != FILL_W'(AVG_DEPTH)) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	assign rsp.total = total_q;
	assign rsp.fill  = fill_q;

endmodule

`default_nettype wire

>>> rtl/core/ppt_ctrl.sv
// Item sequencer: pulse bookkeeping, update timing and the rpm computation.
// Depends on ppt_pkg; drives ppt_divider and ppt_history through structs.
`default_nettype none

module ppt_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire ppt_pkg::ppt_in_t       in_word,
	output logic                        in_stall,
	input  wire ppt_pkg::ppt_cfg_t      cfg,
	input  wire logic                   slot_free,
	output logic                        emit,
	output ppt_pkg::ppt_out_t           result,
	output ppt_pkg::ppt_div_req_t       div_req,
	input  wire ppt_pkg::ppt_div_rsp_t  div_rsp,
	output ppt_pkg::ppt_hist_req_t      hist_req,
	input  wire ppt_pkg::ppt_hist_rsp_t hist_rsp
);
	import ppt_pkg::*;

	ppt_state_t state_q, state_d;

	// item being worked on
	logic              op_q;
	logic [TIME_W-1:0] t_q;
	logic [TIME_W-1:0] diff_q;

	// architectural state
	logic               pulse_seen_q;
	logic [TIME_W-1:0]  last_pulse_q;
	logic [SUM_W-1:0]   period_sum_q;
	logic [COUNT_W-1:0] count_q;
	logic               started_q;
	logic [TIME_W-1:0]  last_update_q;
	logic [RPM_W-1:0]   rpm_held_q;
	logic               running_held_q;

	// per-update scratch and result flags
	logic [RPM_W-1:0] rpm_q;
	logic             running_q;
	logic             updated_q;
	logic             changed_q;

	logic [SUM_W:0]   sum_ext;
	logic [SUM_W-1:0] sum_sat;
	logic [RPM_W-1:0] rpm_sat;
	logic [RPM_W-1:0] avg;
	logic             rate_ok;

	assign sum_ext = {1'b0, period_sum_q} + {1'b0, diff_q};
	assign sum_sat = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
	assign rpm_sat = (|div_rsp.quotient[DIV_W-1:RPM_W]) ? '1 : div_rsp.quotient[RPM_W-1:0];
	assign avg     = div_rsp.quotient[RPM_W-1:0];
	assign rate_ok = pulse_seen_q && (diff_q < TIME_W'(cfg.pulse_timeout_us))
		&& (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d           = state_q;
		div_req.start     = 1'b0;
		div_req.steps     = DSTEP_W'(DIV_W);
		div_req.dividend  = period_sum_q;
		div_req.divisor   = DIV_W'(count_q);
		hist_req.push     = 1'b0;
		hist_req.value    = rpm_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_DIFF;
				end
			end
			ST_DIFF: begin
				if (op_q == OP_PULSE) begin
					state_d = ST_PULSE;
				end else if (!started_q) begin
					state_d = ST_EMIT;
				end else begin
					state_d = ST_TICK;
				end
			end
			ST_PULSE: begin
				state_d = ST_EMIT;
			end
			ST_TICK: begin
				state_d = (diff_q < TIME_W'(cfg.update_period_us)) ? ST_EMIT : ST_CHECK;
			end
			ST_CHECK: begin
				if (rate_ok) begin
					div_req.start = 1'b1;
					state_d       = ST_DIV_PER;
				end else begin
					state_d = ST_PUSH;
				end
			end
			ST_DIV_PER: begin
				if (div_rsp.done) begin
					if (div_rsp.quotient == '0) begin
						state_d = ST_PUSH;
					end else begin
						div_req.start    = 1'b1;
						div_req.steps    = DSTEP_W'(NUM_W);
						div_req.dividend = DIV_W'(RPM_NUM) << (DIV_W - NUM_W);
						div_req.divisor  = div_rsp.quotient;
						state_d          = ST_DIV_RPM;
					end
				end
			end
			ST_DIV_RPM: begin
				if (div_rsp.done) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				hist_req.push = 1'b1;
				state_d       = ST_AVG;
			end
			ST_AVG: begin
				div_req.start    = 1'b1;
				div_req.steps    = DSTEP_W'(TOT_W);
				div_req.dividend = DIV_W'(hist_rsp.total) << (DIV_W - TOT_W);
				div_req.divisor  = DIV_W'(hist_rsp.fill);
				state_d          = ST_DIV_AVG;
			end
			ST_DIV_AVG: begin
				if (div_rsp.done) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				op_q <= in_word.op;
				t_q  <= in_word.time_us;
			end
			ST_DIFF: begin
				diff_q <= t_q - ((op_q == OP_PULSE) ? last_pulse_q : last_update_q);
			end
			ST_TICK: begin
				diff_q <= t_q - last_pulse_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_seen_q   <= 1'b0;
			last_pulse_q   <= '0;
			period_sum_q   <= '0;
			count_q        <= '0;
			started_q      <= 1'b0;
			last_update_q  <= '0;
			rpm_held_q     <= '0;
			running_held_q <= 1'b0;
			rpm_q          <= '0;
			running_q      <= 1'b0;
			updated_q      <= 1'b0;
			changed_q      <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						updated_q <= 1'b0;
						changed_q <= 1'b0;
					end
				end
				ST_DIFF: begin
					if (op_q == OP_TICK && !started_q) begin
						started_q     <= 1'b1;
						last_update_q <= t_q;
					end
				end
				ST_PULSE: begin
					if (!pulse_seen_q) begin
						pulse_seen_q <= 1'b1;
						last_pulse_q <= t_q;
					end else if (diff_q >= TIME_W'(cfg.min_pulse_interval_us)) begin
						last_pulse_q <= t_q;
						period_sum_q <= sum_sat;
						if (count_q != '1) begin
							count_q <= count_q + COUNT_W'(1);
						end
					end
				end
				ST_CHECK: begin
					if (!rate_ok) begin
						rpm_q     <= '0;
						running_q <= 1'b0;
					end
				end
				ST_DIV_PER: begin
					if (div_rsp.done && div_rsp.quotient == '0) begin
						rpm_q     <= '0;
						running_q <= 1'b0;
					end
				end
				ST_DIV_RPM: begin
					if (div_rsp.done) begin
						rpm_q     <= rpm_sat;
						running_q <= rpm_sat >= cfg.running_threshold_rpm;
					end
				end
				ST_DIV_AVG: begin
					if (div_rsp.done) begin
						rpm_held_q     <= avg;
						running_held_q <= running_q;
						changed_q      <= rpm_q != avg;
						updated_q      <= 1'b1;
						period_sum_q   <= '0;
						count_q        <= '0;
						last_update_q  <= t_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign in_stall           = state_q != ST_IDLE;
	assign emit               = state_q == ST_EMIT;
	assign result.rpm_avg     = rpm_held_q;
	assign result.running     = running_held_q;
	assign result.updated     = updated_q;
	assign result.rpm_changed = changed_q;

endmodule

`default_nettype wire

>>> rtl/core/ppt_checker.sv
// Port-level checker for the tachometer, attached by the bind at the end.
// Depends on ppt_pkg and the macros in pulse_period_tachometer_assert.svh.
`default_nettype none

`include "pulse_period_tachometer_assert.svh"

module ppt_checker (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire ppt_pkg::ppt_out_t out_word
);
	import ppt_pkg::*;

	// a stalled result word holds
	`PPT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_word), "stalled output word changed")

	// one word at a time: busy right after an accept
	`PPT_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall, "input taken while an item is in work")

	// no result can appear the cycle after an accept
	`PPT_ASSERT_NEXT(a_no_instant_result, clk, arst_n, in_valid && !in_stall, !$rose(out_valid), "result appeared without work cycles")

	// a change flag only comes with an update
	`PPT_ASSERT_NOW(a_changed_needs_update, clk, arst_n, out_valid && out_word.rpm_changed, out_word.updated, "rpm_changed set without update")

endmodule

bind pulse_period_tachometer ppt_checker u_ppt_checker (.*);

`default_nettype wire

>>> tb/tacho_checker.sv
`timescale 1ns / 1ps
// Checker for the pulse period tachometer: mirrors the rpm arithmetic, queues the
// word each input word must produce and compares the output words in order.
// Depends on ppt_pkg only; watches the block's ports and hands back an error count.
module tacho_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic                       in_stall,
	input  wire ppt_pkg::ppt_in_t           in_word,
	input  wire logic                       out_valid,
	input  wire logic                       out_stall,
	input  wire ppt_pkg::ppt_out_t          out_word,
	input  wire logic                       cfg_we,
	input  wire logic [ppt_pkg::CIDX_W-1:0] cfg_index,
	input  wire logic [ppt_pkg::CFG_W-1:0]  cfg_data,
	output int                              errors,
	output int                              readings_owed
);
	import ppt_pkg::*;

	logic [MIN_W-1:0]   min_gap_us;
	logic [TMO_W-1:0]   stop_after_us;
	logic [RPM_W-1:0]   run_rpm;
	logic [UPD_W-1:0]   update_every_us;

	logic               seen_pulse;
	logic [TIME_W-1:0]  pulse_at;
	logic [SUM_W-1:0]   sum_us;
	logic [COUNT_W-1:0] n_intervals;
	logic               timing_started;
	logic [TIME_W-1:0]  update_at;
	logic [RPM_W-1:0]   history [AVG_DEPTH];
	logic [POS_W-1:0]   slot;
	logic [FILL_W-1:0]  filled;
	logic [31:0]        hist_sum;
	logic [RPM_W-1:0]   avg_rpm;
	logic               running;

	ppt_out_t           readings_due [$];

	// Advance the tachometer by one input word and return the word it answers with.
	function automatic ppt_out_t next_reading(input ppt_in_t w);
		logic [TIME_W-1:0] t, dt, per;
		logic [SUM_W:0]    wide_sum;
		logic [63:0]       raw;
		logic [RPM_W-1:0]  rpm;
		logic              run, did_update, changed;
		ppt_out_t          r;
		t = w.time_us;
		rpm = '0;
		run = 1'b0;
		did_update = 1'b0;
		changed = 1'b0;
		if (w.op == OP_PULSE) begin
			dt = t - pulse_at;
			if (!seen_pulse || dt >= TIME_W'(min_gap_us)) begin
				if (seen_pulse) begin
					wide_sum = {1'b0, sum_us} + {1'b0, dt};
					sum_us = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
					if (n_intervals != '1)
						n_intervals = n_intervals + 1'b1;
				end
				seen_pulse = 1'b1;
				pulse_at = t;
			end
		end else if (!timing_started) begin
			timing_started = 1'b1;
			update_at = t;
		end else if (TIME_W'(t - update_at) >= TIME_W'(update_every_us)) begin
			dt = t - pulse_at;
			if (seen_pulse && dt < TIME_W'(stop_after_us) && n_intervals != '0) begin
				per = sum_us / TIME_W'(n_intervals);
				if (per != '0) begin
					raw = 64'(RPM_NUM) / 64'(per);
					rpm = (raw > 64'd65535) ? '1 : raw[RPM_W-1:0];
					run = rpm >= run_rpm;
				end
			end
			// truncated moving average over the last AVG_DEPTH raw values
			hist_sum = hist_sum - 32'(history[slot]) + 32'(rpm);
			history[slot] = rpm;
			slot = (slot == POS_W'(AVG_DEPTH - 1)) ? '0 : slot + 1'b1;
			if (filled < FILL_W'(AVG_DEPTH))
				filled = filled + 1'b1;
			avg_rpm = RPM_W'(hist_sum / 32'(filled));
			running = run;
			changed = rpm != avg_rpm;
			did_update = 1'b1;
			sum_us = '0;
			n_intervals = '0;
			update_at = t;
		end
		r.rpm_avg = avg_rpm;
		r.running = running;
		r.updated = did_update;
		r.rpm_changed = changed;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ppt_out_t want;
		if (!arst_n) begin
			min_gap_us = MIN_RESET;
			stop_after_us = TMO_RESET;
			run_rpm = THR_RESET;
			update_every_us = UPD_RESET;
			seen_pulse = 1'b0;
			pulse_at = '0;
			sum_us = '0;
			n_intervals = '0;
			timing_started = 1'b0;
			update_at = '0;
			for (int i = 0; i < AVG_DEPTH; i++)
				history[i] = '0;
			slot = '0;
			filled = '0;
			hist_sum = '0;
			avg_rpm = '0;
			running = 1'b0;
			readings_due.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				case (ppt_cfg_idx_t'(cfg_index))
					CFG_MIN_INTERVAL:  min_gap_us = cfg_data[MIN_W-1:0];
					CFG_TIMEOUT:       stop_after_us = cfg_data[TMO_W-1:0];
					CFG_THRESHOLD:     run_rpm = cfg_data[RPM_W-1:0];
					CFG_UPDATE_PERIOD: update_every_us = cfg_data[UPD_W-1:0];
				endcase
			end
			// An output word at this edge can only answer an earlier input word.
			if (out_valid && !out_stall) begin
				if (readings_due.size() == 0) begin
					if (errors < 10)
						$display("checker: output word with nothing due at %0t", $time);
					errors++;
				end else begin
					want = readings_due.pop_front();
					if (out_word.rpm_avg !== want.rpm_avg
							|| out_word.running !== want.running
							|| out_word.updated !== want.updated
							|| out_word.rpm_changed !== want.rpm_changed) begin
						if (errors < 10)
							$display({"checker: mismatch at %0t (expected/actual):",
								" rpm_avg %0d/%0d running %0b/%0b updated %0b/%0b",
								" changed %0b/%0b"}, $time,
								want.rpm_avg, out_word.rpm_avg,
								want.running, out_word.running,
								want.updated, out_word.updated,
								want.rpm_changed, out_word.rpm_changed);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				readings_due.push_back(next_reading(in_word));
		end
		readings_owed = readings_due.size();
	end

endmodule

>>> tb/tb_pulse_period_tachometer.sv
`timescale 1ns / 1ps
// Testbench top for the pulse period tachometer: clock, reset, register writes,
// pulse and tick words sent in bursts, a stalling receiver and the verdict.
// Depends on ppt_pkg, the tachometer RTL and tacho_checker.
module tb_pulse_period_tachometer;
	import ppt_pkg::*;

	localparam int HALF_PERIOD = 4;
	localparam int RANDOM_PHASES = 6;
	localparam int WORDS_PER_PHASE = 180;
	// room for a full update from accept to accept, with margin
	localparam int DRAIN_CYCLES = 150;
	// longest correct silence: the longest sender gap, a full update and a long stall
	localparam int WATCHDOG_LIMIT = 4000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	ppt_in_t           in_word = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	ppt_out_t          out_word;
	logic              cfg_we = 1'b0;
	logic [CIDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data = '0;

	int                errors;
	int                readings_owed;

	// calm turns off both sender gaps and receiver stalls for a stretch
	logic              calm = 1'b0;
	int                burst_left = 0;
	int                stall_left = 0;
	int                idle_cycles = 0;

	// shape of the rotation being simulated in the current phase
	logic [TIME_W-1:0] now_us;
	int unsigned       period_us;
	int unsigned       min_us;
	int unsigned       tmo_us;

	always #HALF_PERIOD clk = ~clk;

	pulse_period_tachometer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tacho_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_word       (in_word),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_word      (out_word),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.errors        (errors),
		.readings_owed (readings_owed)
	);

	// Receiver: alternate free and stalled stretches of random length. Most stalls
	// are short, some run long enough to back the block up behind its output word.
	always @(negedge clk) begin
		if (calm) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (out_stall) begin
			out_stall <= 1'b0;
			stall_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(0, 25);
		end else begin
			out_stall <= 1'b1;
			stall_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(4, 30)
				: $urandom_range(0, 2);
		end
	end

	// Watchdog: count edges at which neither channel moves a word.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Offer one word and hold it until accepted. Open a new burst when the old one
	// is used up, optionally after a gap; long gaps let the block go fully idle.
	// Returns at the falling edge after acceptance with valid still high.
	task automatic send_word(input ppt_op_t op, input logic [TIME_W-1:0] t);
		ppt_in_t w;
		int gap;
		w.op = op;
		w.time_us = t;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = calm ? 0 : ($urandom_range(0, 5) == 0) ? $urandom_range(20, 150)
				: $urandom_range(0, 3);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		in_word <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	// Drop valid and wait until every word sent has been answered: the block is idle.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (readings_owed != 0)
			@(negedge clk);
	endtask

	// Write all four registers on consecutive cycles, starting at a falling edge.
	task automatic set_config(input logic [CFG_W-1:0] min_v, input logic [CFG_W-1:0] tmo_v,
			input logic [CFG_W-1:0] thr_v, input logic [CFG_W-1:0] upd_v);
		cfg_we <= 1'b1;
		cfg_index <= CFG_MIN_INTERVAL;
		cfg_data <= min_v;
		@(negedge clk);
		cfg_index <= CFG_TIMEOUT;
		cfg_data <= tmo_v;
		@(negedge clk);
		cfg_index <= CFG_THRESHOLD;
		cfg_data <= thr_v;
		@(negedge clk);
		cfg_index <= CFG_UPDATE_PERIOD;
		cfg_data <= upd_v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int unsigned r;
		int unsigned thr_v;
		int unsigned upd_v;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed, reset register values (min 1000, timeout 1 s, threshold 500,
		// update period 0.5 s).
		send_word(OP_TICK, 48'd0);            // first tick: only starts the timing
		send_word(OP_PULSE, 48'd10);          // first pulse: only records its time
		send_word(OP_PULSE, 48'd500);         // bounce, closer than min interval
		send_word(OP_PULSE, 48'd20010);
		send_word(OP_PULSE, 48'd40010);
		send_word(OP_TICK, 48'd100000);       // early tick
		send_word(OP_TICK, 48'd500000);       // update: 20 ms period, 3000 rpm
		send_word(OP_TICK, 48'd1000000);      // update with no interval recorded
		send_word(OP_TICK, 48'd2600000);      // update after the pulse timeout
		send_word(OP_PULSE, '1);              // largest timestamp
		send_word(OP_PULSE, 48'd600);         // wraps to a short interval: ignored
		send_word(OP_PULSE, 48'd2000);
		send_word(OP_TICK, 48'd10000);        // time went backwards: update anyway
		drain();

		// Directed, low extremes: no debounce, a 60 s timeout, zero threshold,
		// shortest update period.
		set_config(CFG_W'(0), CFG_W'(60000000), CFG_W'(0), CFG_W'(1));
		send_word(OP_PULSE, 48'd3000);
		send_word(OP_TICK, 48'd3000);
		send_word(OP_PULSE, 48'd3001);
		send_word(OP_PULSE, 48'd3002);
		send_word(OP_TICK, 48'd3003);         // 1 us period: rpm saturates
		send_word(OP_PULSE, 48'd3003);
		send_word(OP_PULSE, 48'd3003);        // zero interval accepted
		send_word(OP_TICK, 48'd3004);         // zero average period: rpm and running 0
		send_word(OP_PULSE, 48'd5);
		send_word(OP_PULSE, 48'd3);           // period sum saturates
		send_word(OP_TICK, 48'd4);            // rpm 0 but running at zero threshold
		send_word(OP_TICK, 48'd4);            // early by zero microseconds
		drain();

		// Random phases: each one simulates a shaft at some speed with jitter,
		// contact bounce, stops and a little noise, under its own register values.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case ($urandom_range(0, 3))
				0:       period_us = $urandom_range(20, 900);   // above the rpm ceiling
				1:       period_us = $urandom_range(900, 20000);
				2:       period_us = $urandom_range(20000, 200000);
				default: period_us = $urandom_range(200000, 2000000);
			endcase
			if (ph == 0) begin
				// large minimum interval, threshold and update period; a 1 us timeout
				period_us = $urandom_range(200000, 2000000);
				min_us = 1000000;
				tmo_us = 1;
				thr_v = 65535;
				upd_v = 60000000;
			end else begin
				min_us = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, period_us / 2);
				if (min_us > 1000000)
					min_us = 1000000;
				tmo_us = ($urandom_range(0, 5) == 0) ? $urandom_range(1, period_us)
					: period_us * $urandom_range(2, 12);
				upd_v = period_us * $urandom_range(1, 8);
				r = $urandom_range(0, 5);
				if (r == 0)
					thr_v = 0;
				else if (r == 1)
					thr_v = 65535;
				else
					thr_v = (60000000 / period_us) * $urandom_range(50, 150) / 100;
				if (thr_v > 65535)
					thr_v = 65535;
			end
			set_config(CFG_W'(min_us), CFG_W'(tmo_us), CFG_W'(thr_v), CFG_W'(upd_v));

			// start anywhere in the 48-bit range; one phase runs across the wrap
			now_us = {16'($urandom), $urandom};
			if (ph == 2)
				now_us = '1 - TIME_W'(period_us * 30);

			for (int k = 0; k < WORDS_PER_PHASE; k++) begin
				if (k % 60 == 0)
					calm <= ($urandom_range(0, 3) == 0);
				r = $urandom_range(0, 99);
				if (r < 55) begin
					// next pulse of the rotation, period within +-1/8
					now_us += TIME_W'(period_us - period_us / 8
						+ $urandom_range(0, period_us / 4));
					send_word(OP_PULSE, now_us);
				end else if (r < 65) begin
					// bounce, up to exactly the min interval after the last time
					now_us += TIME_W'($urandom_range(0, min_us));
					send_word(OP_PULSE, now_us);
				end else if (r < 89) begin
					now_us += TIME_W'($urandom_range(0, period_us));
					send_word(OP_TICK, now_us);
				end else if (r < 95) begin
					// engine stops: silence past the timeout, then a tick
					now_us += TIME_W'(tmo_us) + TIME_W'($urandom_range(0, period_us));
					send_word(OP_TICK, now_us);
				end else begin
					// noise: any kind of word at any time, backwards included
					send_word(($urandom_range(0, 1) == 0) ? OP_PULSE : OP_TICK,
						{16'($urandom), $urandom});
				end
			end
			drain();
		end

		// Wait out anything the block might still emit, then give the verdict.
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
